### hdl/lsb_stego_text_extract_core_assert.svh
// Assertion macros shared by the decoder RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LSB_STEGO_TEXT_EXTRACT_CORE_ASSERT_SVH
`define LSB_STEGO_TEXT_EXTRACT_CORE_ASSERT_SVH

// Same-cycle implication.
`define LSBX_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LSBX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lsbx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsbx_pkg;

	localparam int CHAN_W     = 8;
	localparam int ACC_W      = 8;
	localparam int SLOT_W     = 4;
	localparam int K_W        = 4;
	localparam int NUM_CHAN   = 3;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;
	localparam int FIFO_DEPTH = 4;

	// register index is paddr[2] (one register, word addressed)
	localparam logic REG_BITS_PER_CHANNEL = 1'b0;
	localparam logic [K_W-1:0] BITS_RESET = K_W'(1);

	typedef struct packed {
		logic [ACC_W-1:0] char_value;
		logic             end_of_text;
		logic             last_of_pixel;
	} result_t;

	// up to two results per pixel
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	// 0 -> 1, 9..15 -> 8
	function automatic logic [K_W-1:0] eff_bits(input logic [K_W-1:0] raw);
		logic [K_W-1:0] k;
		k = raw;
		if (raw == '0)
			k = K_W'(1);
		else if (raw > K_W'(8))
			k = K_W'(8);
		return k;
	endfunction

	// slot limit for k = 1..8
	function automatic logic [SLOT_W-1:0] slot_limit(input logic [K_W-1:0] k);
		logic [SLOT_W-1:0] lim;
		unique case (k)
			K_W'(1):           lim = SLOT_W'(8);
			K_W'(2):           lim = SLOT_W'(4);
			K_W'(3), K_W'(4):  lim = SLOT_W'(2);
			default:           lim = SLOT_W'(1);
		endcase
		return lim;
	endfunction

	function automatic logic [CHAN_W-1:0] low_mask(input logic [K_W-1:0] k);
		logic [CHAN_W-1:0] m;
		unique case (k)
			K_W'(1): m = 8'h01;
			K_W'(2): m = 8'h03;
			K_W'(3): m = 8'h07;
			K_W'(4): m = 8'h0F;
			K_W'(5): m = 8'h1F;
			K_W'(6): m = 8'h3F;
			K_W'(7): m = 8'h7F;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### hdl/lsb_stego_text_extract_core.sv
`timescale 1ns / 1ps
`default_nettype none
// LSB steganography text extractor.
// Pixel channel: pixel_valid/pixel_stall carry one RGB pixel per transaction
// (red, green, blue). Result channel: result_valid/result_stall carry one
// recovered byte per transaction with end_of_text and last_of_pixel flags.
// A pixel yields zero, one or two results; after the end-of-text result all
// further pixels are taken and dropped until reset.
// A pixel taken into input register s1 is decoded as it leaves s1 and its
// results are written to the result queue. Throughput: one pixel per cycle
// while pixel_stall is low; the output port delivers one result per cycle
// while result_stall is low (k >= 5 averages 1.5 results per pixel).
// The input register stalls only when the result queue has under two slots.
// Receiver stall: results wait in a FIFO_DEPTH-entry queue; pixel_stall rises
// once the queue cannot absorb two more results.
// Config: bits_per_channel at byte address 0 over an APB-style port, reset
// value 1; to be written only while idle, a rule the user keeps, unenforced.
// Reset clears accumulator, slot count, end-of-text flag, s1, result queue.
module lsb_stego_text_extract_core #(
	parameter int FIFO_DEPTH = lsbx_pkg::FIFO_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lsbx_pkg::ADDR_W-1:0] paddr,
	input  wire logic [lsbx_pkg::DATA_W-1:0] pwdata,
	output logic      [lsbx_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	// pixel channel
	input  wire logic                        pixel_valid,
	output logic                             pixel_stall,
	input  wire logic [lsbx_pkg::CHAN_W-1:0] red,
	input  wire logic [lsbx_pkg::CHAN_W-1:0] green,
	input  wire logic [lsbx_pkg::CHAN_W-1:0] blue,
	// result channel
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic      [lsbx_pkg::ACC_W-1:0]  char_value,
	output logic                             end_of_text,
	output logic                             last_of_pixel
);
	import lsbx_pkg::*;

	logic [K_W-1:0]    bits_q;
	logic              valid_s1;
	logic [CHAN_W-1:0] red_s1;
	logic [CHAN_W-1:0] green_s1;
	logic [CHAN_W-1:0] blue_s1;
	logic              room2;
	logic              advance;
	logic              take;
	logic              reg_hit;
	push_t             push;
	result_t           head;

	// APB: pready always high, single register at index 0
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_BITS_PER_CHANNEL);
	assign prdata  = reg_hit ? DATA_W'(bits_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			bits_q <= pwdata[K_W-1:0];
		end
	end

	// s1 holds the pixel until the queue can take up to two results
	assign advance     = valid_s1 && room2;
	assign pixel_stall = valid_s1 && !room2;
	assign take        = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	lsbx_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (advance),
		.bits_raw (bits_q),
		.red      (red_s1),
		.green    (green_s1),
		.blue     (blue_s1),
		.push     (push)
	);

	lsbx_res_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_res_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.head         (head),
		.room2        (room2)
	);

	assign char_value    = head.char_value;
	assign end_of_text   = head.end_of_text;
	assign last_of_pixel = head.last_of_pixel;

endmodule

`default_nettype wire

### hdl/lsbx_decode.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_stego_text_extract_core_assert.svh"

module lsbx_decode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [lsbx_pkg::K_W-1:0]    bits_raw,
	input  wire logic [lsbx_pkg::CHAN_W-1:0] red,
	input  wire logic [lsbx_pkg::CHAN_W-1:0] green,
	input  wire logic [lsbx_pkg::CHAN_W-1:0] blue,
	output lsbx_pkg::push_t                  push
);
	import lsbx_pkg::*;

	logic [ACC_W-1:0]  acc_q;
	logic [SLOT_W-1:0] slot_q;
	logic              done_q;

	logic [ACC_W-1:0]  acc_nx;
	logic [SLOT_W-1:0] slot_nx;
	logic              done_nx;
	push_t             res;
	logic [CHAN_W-1:0] chan [NUM_CHAN];

	assign chan[0] = red;
	assign chan[1] = green;
	assign chan[2] = blue;

	// three channel slots in sequence, narrow values
	always_comb begin
		logic [K_W-1:0]    k;
		logic [SLOT_W-1:0] lim;
		logic [CHAN_W-1:0] piece;
		logic [7:0]        offset;
		logic [ACC_W-1:0]  shifted;
		result_t           rec;
		k       = eff_bits(bits_raw);
		lim     = slot_limit(k);
		piece   = '0;
		offset  = '0;
		shifted = '0;
		rec     = '0;
		acc_nx  = acc_q;
		slot_nx = slot_q;
		done_nx = done_q;
		res     = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			if (!done_nx) begin
				if (slot_nx > lim) begin
					rec = '0;
					if (acc_nx == '0) begin
						rec.end_of_text = 1'b1;
						done_nx         = 1'b1;
					end else begin
						rec.char_value = acc_nx;
					end
					if (res.n == 2'd0)
						res.r0 = rec;
					else
						res.r1 = rec;
					res.n   = res.n + 2'd1;
					acc_nx  = '0;
					slot_nx = '0;
				end
			end
			if (!done_nx) begin
				piece   = chan[c] & low_mask(k);
				offset  = {4'b0, k} * {4'b0, slot_nx};
				shifted = piece << offset[2:0];
				if (offset < 8'd8)
					acc_nx = acc_nx + shifted;
				slot_nx = slot_nx + SLOT_W'(1);
			end
		end
		if (res.n == 2'd1)
			res.r0.last_of_pixel = 1'b1;
		if (res.n == 2'd2)
			res.r1.last_of_pixel = 1'b1;
	end

	always_comb begin
		push = res;
		if (!go)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			slot_q <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			acc_q  <= acc_nx;
			slot_q <= slot_nx;
			done_q <= done_nx;
		end
	end

	`LSBX_ASSERT_NEXT(a_done_sticks, done_q, done_q, "end of text flag cleared")
	`LSBX_ASSERT_HOLDS(a_done_silent, done_q, res.n == 2'd0, "result after end of text")
	`LSBX_ASSERT_HOLDS(a_end_is_final, res.n == 2'd2, !res.r0.end_of_text,
		"result follows end of text")

endmodule

`default_nettype wire

### hdl/lsbx_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_stego_text_extract_core_assert.svh"

module lsbx_res_fifo #(
	parameter int DEPTH = lsbx_pkg::FIFO_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsbx_pkg::push_t   push,
	input  wire logic              result_stall,
	output logic                   result_valid,
	output lsbx_pkg::result_t      head,
	output logic                   room2
);
	import lsbx_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [PTR_W-1:0] wr_next;

	function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign result_valid = (count_q != '0);
	assign head         = mem_q[rd_q];
	assign pop          = result_valid && !result_stall;
	assign room2        = (count_q <= CNT_W'(DEPTH - 2));
	assign wr_next      = inc(wr_q);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr_next] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.n == 2'd1)
				wr_q <= wr_next;
			else if (push.n == 2'd2)
				wr_q <= inc(wr_next);
			if (pop)
				rd_q <= inc(rd_q);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	`LSBX_ASSERT_HOLDS(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue overfilled")
	`LSBX_ASSERT_HOLDS(a_push_room, push.n != 2'd0, room2, "results pushed without room")

endmodule

`default_nettype wire
